@@ hw/rtl/ctt_pkg.sv @@
// ============================================================================
// ctt_pkg: shared types and constants for the connection table
// Holds the table size, status and command codes, item layouts and the
// command and status groups that join the controller to the datapath.
// ============================================================================
package ctt_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = SLOT_W + 1;

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  SLOT_COUNT = CNT_W'(TABLE_SLOTS);

    localparam logic [1:0] ST_FOUND       = 2'd0;
    localparam logic [1:0] ST_CREATED     = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd3;

    localparam logic CMD_TUPLE = 1'b0;
    localparam logic CMD_BY_ID = 1'b1;

    localparam logic CFG_IDLE_TIMEOUT   = 1'b0;
    localparam logic CFG_SWEEP_INTERVAL = 1'b1;

    localparam logic [15:0] IDLE_TIMEOUT_RST   = 16'd30;
    localparam logic [15:0] SWEEP_INTERVAL_RST = 16'd30;

    typedef struct packed {
        logic        command;
        logic [31:0] now;
        logic [15:0] main_handle;
        logic [5:0]  session_id;
        logic [63:0] link_addr_hi;
        logic [63:0] link_addr_lo;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [47:0] port_triple;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [15:0] entry_handle;
        logic [63:0] entry_link_hi;
        logic [63:0] entry_link_lo;
        logic [15:0] entry_link_port;
        logic [63:0] entry_src_hi;
        logic [63:0] entry_src_lo;
        logic [15:0] entry_src_port;
        logic [63:0] entry_dst_hi;
        logic [63:0] entry_dst_lo;
    } out_item_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [63:0] link_hi;
        logic [63:0] link_lo;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [47:0] ports;
    } key_t;

    typedef struct packed {
        logic load_in;
        logic scan_start;
        logic scan_run;
        logic fill;
        logic sweep_run;
        logic id_read;
        logic id_resp;
        logic push;
    } ctt_cmd_t;

    typedef struct packed {
        logic hit;
        logic last;
        logic sweep_due;
        logic out_free;
    } ctt_stat_t;

endpackage

@@ hw/rtl/ctt_if.sv @@
// ============================================================================
// ctt_if: item channels of the connection table
// Valid/ready channels for request items and result items.
// ============================================================================
interface ctt_in_if import ctt_pkg::*;;
    logic     valid;
    logic     ready;
    in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ctt_out_if import ctt_pkg::*;;
    logic      valid;
    logic      ready;
    out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/connection_table_with_aging.sv @@
// ============================================================================
// connection_table_with_aging: connection tracking table with aging sweep
// Looks up or creates connection entries by their full address tuple, looks
// entries up by slot id, and evicts stale entries in a periodic sweep.
// ============================================================================
//
//   channel   direction  handshake        carries
//   in_ch     sink       valid / ready    one request item
//   out_ch    source     valid / ready    one result item per request
//   cfg       write      cfg_we           idle_timeout, sweep_interval
//
// A lookup by slot id reads the entry at that slot and then forms its result.
// A tuple lookup scans the slots through the entry memory's single read port,
// one slot a cycle, until a hit or the last slot; a miss then tries to create
// an entry, and when the sweep is due a pass over every slot follows on the
// timestamp memory. Reset clears all valid bits at once, so no clearing pass
// is needed. A waiting result sits in the output register while the next
// item is accepted; only the hand-off of the following result waits on it.
//
module connection_table_with_aging import ctt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ctt_in_if.sink      in_ch,
    ctt_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    ctt_cmd_t  cmd;
    ctt_stat_t stat;
    logic      idle;
    logic      in_fire;

    // Items are taken only while the sequencer is idle; each item owns the
    // scan counter and the memory read ports until its result is handed off.
    assign in_ch.ready = idle;
    assign in_fire     = in_ch.valid && idle;

    ctt_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_command (in_ch.payload.command),
        .stat       (stat),
        .cmd        (cmd),
        .idle       (idle)
    );

    // The datapath also holds the configuration registers and the output
    // register that decouples the result from the downstream stall.
    ctt_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_item   (in_ch.payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_item  (out_ch.payload)
    );

endmodule

@@ hw/rtl/ctt_ctrl.sv @@
// ============================================================================
// ctt_ctrl: sequencer of the connection table
// Steps one item through scan, fill, aging sweep or id lookup, then hands
// the result to the output register.
// ============================================================================
module ctt_ctrl import ctt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      in_command,
    input  ctt_stat_t stat,
    output ctt_cmd_t  cmd,
    output logic      idle
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_FILL   = 7'b0000100,
        S_SWEEP  = 7'b0001000,
        S_ID_RD  = 7'b0010000,
        S_ID_RSP = 7'b0100000,
        S_POST   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load_in    = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = (in_command == CMD_BY_ID) ? S_ID_RD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.hit)
                    state_next = S_POST;
                else if (stat.last)
                    state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.fill       = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = stat.sweep_due ? S_SWEEP : S_POST;
            end
            S_SWEEP:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.last)
                    state_next = S_POST;
            end
            S_ID_RD:
            begin
                cmd.id_read = 1'b1;
                state_next  = S_ID_RSP;
            end
            S_ID_RSP:
            begin
                cmd.id_resp = 1'b1;
                state_next  = S_POST;
            end
            S_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign idle = (state_reg == S_IDLE);

endmodule

@@ hw/rtl/ctt_dp.sv @@
// ============================================================================
// ctt_dp: datapath of the connection table
// Entry and timestamp memories, valid bits, scan counter with a one-deep
// read pipeline, match and age compares, result and output registers.
// ============================================================================
module ctt_dp import ctt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctt_cmd_t  cmd,
    output ctt_stat_t stat,
    input  in_item_t  in_item,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [15:0] cfg_data,
    input  logic      out_ready,
    output logic      out_valid,
    output out_item_t out_item
);

    key_t        key_mem  [TABLE_SLOTS];
    logic [31:0] seen_mem [TABLE_SLOTS];

    in_item_t          item_reg, item_next;
    logic [15:0]       idle_timeout_reg, idle_timeout_next;
    logic [15:0]       sweep_interval_reg, sweep_interval_next;
    logic [31:0]       last_sweep_reg, last_sweep_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0] rd_idx_reg, rd_idx_next;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_idx_reg, free_idx_next;
    logic              skip_vld_reg, skip_vld_next;
    logic [SLOT_W-1:0] skip_idx_reg, skip_idx_next;
    out_item_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;
    key_t              key_rd_reg;
    logic [31:0]       seen_rd_reg;

    key_t              in_key;
    logic [SLOT_W-1:0] id_idx;
    logic              id_ok;
    logic              issue;
    logic              compare;
    logic              hit;
    logic              evict;
    logic              fill_wr;
    logic              seen_we;
    logic [SLOT_W-1:0] seen_waddr;
    logic [SLOT_W-1:0] key_raddr;

    function automatic out_item_t entry_result(logic [1:0] st, logic [5:0] sl, key_t k);
        out_item_t r;
        r.status          = st;
        r.slot            = sl;
        r.entry_handle    = k.handle;
        r.entry_link_hi   = k.link_hi;
        r.entry_link_lo   = k.link_lo;
        r.entry_link_port = k.ports[47:32];
        r.entry_src_hi    = k.src_hi;
        r.entry_src_lo    = k.src_lo;
        r.entry_src_port  = k.ports[31:16];
        r.entry_dst_hi    = k.dst_hi;
        r.entry_dst_lo    = k.dst_lo;
        return r;
    endfunction

    function automatic out_item_t empty_result(logic [1:0] st);
        out_item_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    assign in_key.handle  = item_reg.main_handle;
    assign in_key.link_hi = item_reg.link_addr_hi;
    assign in_key.link_lo = item_reg.link_addr_lo;
    assign in_key.src_hi  = item_reg.src_addr_hi;
    assign in_key.src_lo  = item_reg.src_addr_lo;
    assign in_key.dst_hi  = item_reg.dst_addr_hi;
    assign in_key.dst_lo  = item_reg.dst_addr_lo;
    assign in_key.ports   = item_reg.port_triple;

    assign id_idx  = SLOT_W'(item_reg.session_id);
    assign id_ok   = (32'(item_reg.session_id) < TABLE_SLOTS) && valid_reg[id_idx];
    assign issue   = (cmd.scan_run || cmd.sweep_run) && (cnt_reg != SLOT_COUNT);
    assign compare = (cmd.scan_run || cmd.sweep_run) && rd_vld_reg;
    assign hit     = cmd.scan_run && rd_vld_reg && valid_reg[rd_idx_reg]
                     && (key_rd_reg == in_key);
    // An entry ages out if its time lies in the future or it has been idle
    // longer than the timeout; the entry created by this item is spared.
    assign evict   = cmd.sweep_run && rd_vld_reg && valid_reg[rd_idx_reg]
                     && !(skip_vld_reg && (skip_idx_reg == rd_idx_reg))
                     && ((seen_rd_reg > item_reg.now)
                         || (({1'b0, seen_rd_reg} + {17'd0, idle_timeout_reg})
                             < {1'b0, item_reg.now}));
    assign fill_wr = cmd.fill && free_found_reg;

    assign stat.hit       = hit;
    assign stat.last      = compare && (rd_idx_reg == LAST_SLOT);
    assign stat.sweep_due = (item_reg.now < last_sweep_reg)
                            || ({1'b0, item_reg.now}
                                > ({1'b0, last_sweep_reg} + {17'd0, sweep_interval_reg}));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign seen_we    = hit || fill_wr || (cmd.id_resp && id_ok);
    assign seen_waddr = hit ? rd_idx_reg : (fill_wr ? free_idx_reg : id_idx);
    assign key_raddr  = cmd.id_read ? id_idx : cnt_reg[SLOT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (fill_wr)
            key_mem[free_idx_reg] <= in_key;
        key_rd_reg <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
            seen_mem[seen_waddr] <= item_reg.now;
        seen_rd_reg <= seen_mem[cnt_reg[SLOT_W-1:0]];
    end

    always_comb
    begin
        item_next           = item_reg;
        idle_timeout_next   = idle_timeout_reg;
        sweep_interval_next = sweep_interval_reg;
        last_sweep_next     = last_sweep_reg;
        valid_next          = valid_reg;
        cnt_next            = cnt_reg;
        rd_vld_next         = issue;
        rd_idx_next         = cnt_reg[SLOT_W-1:0];
        free_found_next     = free_found_reg;
        free_idx_next       = free_idx_reg;
        skip_vld_next       = skip_vld_reg;
        skip_idx_next       = skip_idx_reg;
        res_next            = res_reg;
        out_valid_next      = out_valid_reg;
        out_item_next       = out_item_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_IDLE_TIMEOUT)
                idle_timeout_next = cfg_data;
            else
                sweep_interval_next = cfg_data;
        end

        if (cmd.load_in)
            item_next = in_item;

        if (cmd.scan_start)
        begin
            cnt_next        = '0;
            rd_vld_next     = 1'b0;
            free_found_next = 1'b0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.scan_run && rd_vld_reg && !valid_reg[rd_idx_reg] && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_idx_next   = rd_idx_reg;
        end

        if (hit)
            res_next = entry_result(ST_FOUND, 6'(rd_idx_reg), key_rd_reg);

        if (cmd.fill)
        begin
            if (free_found_reg)
            begin
                valid_next[free_idx_reg] = 1'b1;
                res_next      = entry_result(ST_CREATED, 6'(free_idx_reg), in_key);
                skip_vld_next = 1'b1;
                skip_idx_next = free_idx_reg;
            end
            else
            begin
                res_next      = empty_result(ST_FULL);
                skip_vld_next = 1'b0;
            end
            if (stat.sweep_due)
                last_sweep_next = item_reg.now;
        end

        if (evict)
            valid_next[rd_idx_reg] = 1'b0;

        if (cmd.id_resp)
        begin
            if (id_ok)
                res_next = entry_result(ST_FOUND, 6'(id_idx), key_rd_reg);
            else
                res_next = empty_result(ST_NOT_PRESENT);
        end

        if (cmd.push)
        begin
            out_valid_next = 1'b1;
            out_item_next  = res_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg   <= IDLE_TIMEOUT_RST;
            sweep_interval_reg <= SWEEP_INTERVAL_RST;
            last_sweep_reg     <= '0;
            valid_reg          <= '0;
            cnt_reg            <= '0;
            rd_vld_reg         <= 1'b0;
            free_found_reg     <= 1'b0;
            skip_vld_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            idle_timeout_reg   <= idle_timeout_next;
            sweep_interval_reg <= sweep_interval_next;
            last_sweep_reg     <= last_sweep_next;
            valid_reg          <= valid_next;
            cnt_reg            <= cnt_next;
            rd_vld_reg         <= rd_vld_next;
            free_found_reg     <= free_found_next;
            skip_vld_reg       <= skip_vld_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        rd_idx_reg   <= rd_idx_next;
        free_idx_reg <= free_idx_next;
        skip_idx_reg <= skip_idx_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ hw/rtl/ctt_checker.sv @@
// ============================================================================
// ctt_checker: port-level checks for the connection table
// Watches the item handshakes on the top level and is bound to it.
// ============================================================================
module ctt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_status
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_status))
        else $error("result changed while stalled");

    // Once an item is taken the block is busy with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while busy");

    // A new result appears only while an item is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without an item in progress");

endmodule

bind connection_table_with_aging ctt_checker u_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.payload.status)
);
